@@ design/cosine_similarity_best_match_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cosine similarity best-match block
// Shared concurrent assertion forms, clocked on clk with rst_n low as disable.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_BEST_MATCH_DEFINES_SVH
`define COSINE_SIMILARITY_BEST_MATCH_DEFINES_SVH

// same-cycle implication
`define CSBM_ASSERT_NOW(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define CSBM_ASSERT_NEXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error(msg);

`endif

@@ design/csbm_pkg.sv @@
// ----------------------------------------------------------------------------
// csbm_pkg
// Widths, job record and sequencer states for the best-match block.
// ----------------------------------------------------------------------------
`default_nettype none
package csbm_pkg;
  localparam int ACC_W   = 34;
  localparam int PROD_W  = 2 * ACC_W;
  localparam int WIDE_W  = 104;
  localparam int SCORE_W = 17;
  localparam int ORD_W   = 16;
  localparam int CNT_W   = 6;
  localparam int BIT_W   = 5;
  localparam int MAX_WINDOWS = 65536;

  localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;
  localparam logic [BIT_W-1:0]   TOP_BIT   = 5'd16;

  typedef struct packed {
    logic [ACC_W-1:0] dot;
    logic [ACC_W-1:0] wsq;
    logic [ACC_W-1:0] tsq;
    logic             slast;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_CMP,
    BK_OUT
  } back_state_t;
endpackage
`default_nettype wire

@@ design/csbm_in_if.sv @@
// ----------------------------------------------------------------------------
// csbm_in_if
// Byte-pair request channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface csbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] window_byte;
  logic [7:0] template_byte;
  logic       window_last;
  logic       search_last;

  modport source (output valid, window_byte, template_byte, window_last, search_last,
                  input ready);
  modport sink (input valid, window_byte, template_byte, window_last, search_last,
                output ready);
endinterface
`default_nettype wire

@@ design/csbm_out_if.sv @@
// ----------------------------------------------------------------------------
// csbm_out_if
// Window result channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface csbm_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] window_score;
  logic        window_valid;
  logic [15:0] best_index;
  logic [16:0] best_score;
  logic        best_found;
  logic        search_done;

  modport source (output valid, window_score, window_valid, best_index, best_score,
                  best_found, search_done, input ready);
  modport sink (input valid, window_score, window_valid, best_index, best_score,
                best_found, search_done, output ready);
endinterface
`default_nettype wire

@@ design/cosine_similarity_best_match.sv @@
// Takes one byte pair per cycle while the two-entry queue has room; a window result
// shows on the output once the back end has run its serial products and its 17-step
// root search (each step a sum state and a compare state); a zero sum of squares skips both.
// Short windows can back up the two-entry queue and stall the input.
// Reset is synchronous, active low: sums, ordinal, best and queue clear at once.
// ----------------------------------------------------------------------------
// cosine_similarity_best_match
// Cosine similarity per window in Q1.16 with best-window search.
// ----------------------------------------------------------------------------
`default_nettype none
module cosine_similarity_best_match import csbm_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  csbm_in_if.sink     in_ch,
  csbm_out_if.source  out_ch
);
  logic      push, pop;
  job_t      push_job, pop_job;
  q_status_t q_stat;

  csbm_front u_front (
    .clk, .rst_n, .in_ch, .q_stat, .push, .push_job
  );

  csbm_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop, .pop_job, .q_stat
  );

  csbm_back u_back (
    .clk, .rst_n, .pop_job, .q_stat, .pop, .out_ch
  );
endmodule
`default_nettype wire

@@ design/csbm_front.sv @@
// ----------------------------------------------------------------------------
// csbm_front
// Saturating multiply-accumulate of dot product and both sums of squares.
// ----------------------------------------------------------------------------
`default_nettype none
module csbm_front import csbm_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  csbm_in_if.sink    in_ch,
  input  q_status_t  q_stat,
  output logic       push,
  output job_t       push_job
);
  logic [ACC_W-1:0] dot_r, wsq_r, tsq_r;
  logic [ACC_W-1:0] dot_nxt, wsq_nxt, tsq_nxt;
  logic             take;

  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc, logic [15:0] p);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + (ACC_W+1)'(p);
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  assign in_ch.ready = !q_stat.full;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    dot_nxt = sat_add(dot_r, in_ch.window_byte * in_ch.template_byte);
    wsq_nxt = sat_add(wsq_r, in_ch.window_byte * in_ch.window_byte);
    tsq_nxt = sat_add(tsq_r, in_ch.template_byte * in_ch.template_byte);
    push = take && in_ch.window_last;
    push_job.dot   = dot_nxt;
    push_job.wsq   = wsq_nxt;
    push_job.tsq   = tsq_nxt;
    push_job.slast = in_ch.search_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      wsq_r <= '0;
      tsq_r <= '0;
    end else if (take) begin
      // clear at window end, the sums travel with the request
      dot_r <= in_ch.window_last ? '0 : dot_nxt;
      wsq_r <= in_ch.window_last ? '0 : wsq_nxt;
      tsq_r <= in_ch.window_last ? '0 : tsq_nxt;
    end
  end
endmodule
`default_nettype wire

@@ design/csbm_queue.sv @@
// ----------------------------------------------------------------------------
// csbm_queue
// Two-entry queue of finished window sums between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module csbm_queue import csbm_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  job_t       push_job,
  input  wire        pop,
  output job_t       pop_job,
  output q_status_t  q_stat
);
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign pop_job      = mem_r[rp_r];
  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.empty = cnt_r == 2'd0;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

@@ design/csbm_back.sv @@
// ----------------------------------------------------------------------------
// csbm_back
// Score sequencer: serial products, bit-wise root search, best tracking.
// ----------------------------------------------------------------------------
`default_nettype none
module csbm_back import csbm_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  job_t       pop_job,
  input  q_status_t  q_stat,
  output logic       pop,
  csbm_out_if.source out_ch
);
  back_state_t state_r, state_nxt;

  logic [PROD_W-1:0]  ma_r, md_r, ab_r, rr_r;
  logic [ACC_W-1:0]   mb_r, mq_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [WIDE_W-1:0]  p_r, qs_r, as_r, t_r;
  logic [BIT_W-1:0]   k_r;
  logic [SCORE_W-1:0] s_r;
  logic               valid_r, slast_r;
  logic [ORD_W-1:0]   ord_r;
  logic [SCORE_W-1:0] best_score_r;
  logic [ORD_W-1:0]   best_ord_r;
  logic               best_seen_r;

  logic               out_valid_r;
  logic [SCORE_W-1:0] o_score_r, o_best_score_r;
  logic [ORD_W-1:0]   o_best_ord_r;
  logic               o_valid_r, o_found_r, o_done_r;

  logic               fire, mul_end, fits, upd;
  logic [PROD_W-1:0]  ab_fin, rr_fin;
  logic [WIDE_W-1:0]  qs_sum;
  logic [SCORE_W-1:0] score;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.window_score = o_score_r;
  assign out_ch.window_valid = o_valid_r;
  assign out_ch.best_index   = o_best_ord_r;
  assign out_ch.best_score   = o_best_score_r;
  assign out_ch.best_found   = o_found_r;
  assign out_ch.search_done  = o_done_r;

  always_comb begin
    ab_fin  = ab_r + (mb_r[0] ? ma_r : '0);
    rr_fin  = rr_r + (mq_r[0] ? md_r : '0);
    mul_end = cnt_r == CNT_W'(ACC_W - 1);
    fits    = t_r <= (WIDE_W'(rr_r) << 32);
    qs_sum  = fits ? qs_r + (as_r << 1) : qs_r;
    score   = !valid_r ? '0 : (s_r > SCORE_ONE ? SCORE_ONE : s_r);
    upd     = valid_r && (!best_seen_r || score >= best_score_r);
    fire    = (state_r == BK_OUT) && (!out_valid_r || out_ch.ready);
    pop     = 1'b0;
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          state_nxt = (pop_job.wsq != '0 && pop_job.tsq != '0) ? BK_MUL : BK_OUT;
        end
      end
      BK_MUL:  if (mul_end) state_nxt = BK_SUM;
      BK_SUM:  state_nxt = BK_CMP;
      BK_CMP:  state_nxt = (k_r == '0) ? BK_OUT : BK_SUM;
      BK_OUT:  if (fire) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        ma_r    <= PROD_W'(pop_job.wsq);
        mb_r    <= pop_job.tsq;
        md_r    <= PROD_W'(pop_job.dot);
        mq_r    <= pop_job.dot;
        ab_r    <= '0;
        rr_r    <= '0;
        cnt_r   <= '0;
        s_r     <= '0;
        valid_r <= pop_job.wsq != '0 && pop_job.tsq != '0;
        slast_r <= pop_job.slast;
      end
      BK_MUL: begin
        ab_r  <= ab_fin;
        rr_r  <= rr_fin;
        ma_r  <= ma_r << 1;
        md_r  <= md_r << 1;
        mb_r  <= mb_r >> 1;
        mq_r  <= mq_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        p_r   <= '0;
        qs_r  <= '0;
        as_r  <= WIDE_W'(ab_fin) << 32;
        k_r   <= TOP_BIT;
      end
      BK_SUM: t_r <= p_r + qs_r + as_r;
      BK_CMP: begin
        if (fits) begin
          p_r      <= t_r;
          s_r[k_r] <= 1'b1;
        end
        if (k_r != '0) begin
          // advance to next bit: rescale partial terms
          qs_r <= qs_sum >> 1;
          as_r <= as_r >> 2;
          k_r  <= k_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r        <= '0;
      best_score_r <= '0;
      best_ord_r   <= '0;
      best_seen_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        if (slast_r) begin
          ord_r        <= '0;
          best_score_r <= '0;
          best_ord_r   <= '0;
          best_seen_r  <= 1'b0;
        end else begin
          ord_r <= (ord_r == ORD_W'(MAX_WINDOWS - 1)) ? '0 : ord_r + 1'b1;
          if (upd) begin
            best_score_r <= score;
            best_ord_r   <= ord_r;
            best_seen_r  <= 1'b1;
          end
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_score_r      <= score;
      o_valid_r      <= valid_r;
      o_best_ord_r   <= upd ? ord_r : best_ord_r;
      o_best_score_r <= upd ? score : best_score_r;
      o_found_r      <= upd || best_seen_r;
      o_done_r       <= slast_r;
    end
  end
endmodule
`default_nettype wire

@@ design/csbm_checker.sv @@
// ----------------------------------------------------------------------------
// csbm_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cosine_similarity_best_match_defines.svh"
module csbm_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [16:0] out_window_score,
  input wire        out_window_valid,
  input wire [15:0] out_best_index,
  input wire [16:0] out_best_score,
  input wire        out_best_found
);
  `CSBM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CSBM_ASSERT_NOW(a_invalid_zero, out_valid && !out_window_valid, out_window_score == 17'd0, "invalid window has a score")
  `CSBM_ASSERT_NOW(a_range, out_valid, out_window_score <= 17'd65536 && out_best_score <= 17'd65536, "score above one")
  `CSBM_ASSERT_NOW(a_no_best, out_valid && !out_best_found, out_best_index == 16'd0 && out_best_score == 17'd0, "best shown without a valid window")
  `CSBM_ASSERT_NOW(a_found, out_valid && out_window_valid, out_best_found && out_best_score >= out_window_score, "valid window not tracked as best")
endmodule

bind cosine_similarity_best_match csbm_checker u_csbm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_window_score (out_ch.window_score),
  .out_window_valid (out_ch.window_valid),
  .out_best_index   (out_ch.best_index),
  .out_best_score   (out_ch.best_score),
  .out_best_found   (out_ch.best_found)
);
`default_nettype wire

@@ test/tb_cosine_similarity_best_match.sv @@
// ----------------------------------------------------------------------------
// tb_cosine_similarity_best_match
// Drives byte-pair requests through the best-match block with random gaps and
// back-pressure, predicts every window result in Q1.16, checks all fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_cosine_similarity_best_match;
  import csbm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [7:0] wb;
    logic [7:0] tb;
    logic       wl;
    logic       sl;
  } pair_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               valid;
    logic [ORD_W-1:0]   bidx;
    logic [SCORE_W-1:0] bscore;
    logic               found;
    logic               done;
  } match_t;

  logic clk;
  logic rst_n;

  csbm_in_if  in_ch ();
  csbm_out_if out_ch ();

  cosine_similarity_best_match i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pair_t  pair_q[$];
  match_t match_q[$];
  int     errors;
  int     results_seen;
  int     idle_cycles;
  int     send_gap;
  int     hold_cnt;
  bit     long_hold_done;

  // predictor state
  logic [ACC_W-1:0]   p_dot, p_wsq, p_tsq;
  logic [ORD_W-1:0]   p_ord, p_best_ord;
  logic [SCORE_W-1:0] p_best;
  logic               p_seen;

  function automatic logic [ACC_W-1:0] sat_acc(logic [ACC_W-1:0] acc, logic [15:0] v);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + v;
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  // largest s in [0,1.0] with s^2 * wsq * tsq <= dot^2 * 2^32
  function automatic logic [SCORE_W-1:0] cosine_q16(logic [ACC_W-1:0] dot,
                                                    logic [ACC_W-1:0] wsq,
                                                    logic [ACC_W-1:0] tsq);
    logic [127:0] rhs, ab, lhs;
    int unsigned lo, hi, mid;
    rhs = ({94'd0, dot} * {94'd0, dot}) << 32;
    ab  = {94'd0, wsq} * {94'd0, tsq};
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = {64'd0, 64'(mid) * 64'(mid)} * ab;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return SCORE_W'(lo);
  endfunction

  task automatic push_pair(logic [7:0] w, logic [7:0] t, logic wl, logic sl);
    pair_t  p;
    match_t m;
    p = '{w, t, wl, sl};
    pair_q.push_back(p);
    p_dot = sat_acc(p_dot, w * t);
    p_wsq = sat_acc(p_wsq, w * w);
    p_tsq = sat_acc(p_tsq, t * t);
    if (wl) begin
      m.valid = (p_wsq != 0) && (p_tsq != 0);
      m.score = '0;
      if (m.valid) begin
        m.score = cosine_q16(p_dot, p_wsq, p_tsq);
        if (!p_seen || m.score >= p_best) begin
          p_best     = m.score;
          p_best_ord = p_ord;
          p_seen     = 1'b1;
        end
      end
      m.bidx   = p_best_ord;
      m.bscore = p_best;
      m.found  = p_seen;
      m.done   = sl;
      match_q.push_back(m);
      p_dot = '0;
      p_wsq = '0;
      p_tsq = '0;
      p_ord = p_ord + 1'b1;
      if (sl) begin
        p_ord      = '0;
        p_best     = '0;
        p_best_ord = '0;
        p_seen     = 1'b0;
      end
    end
  endtask

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (pair_q.size() > 0) begin
        in_ch.valid         <= 1'b1;
        in_ch.window_byte   <= pair_q[0].wb;
        in_ch.template_byte <= pair_q[0].tb;
        in_ch.window_last   <= pair_q[0].wl;
        in_ch.search_last   <= pair_q[0].sl;
        void'(pair_q.pop_front());
        send_gap <= (pair_q.size() > 100000) ? 0 : pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor, receiver stalls and watchdog
  always @(posedge clk) begin
    match_t m;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= 0;
      idle_cycles  <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result score=%0d", $time, out_ch.window_score);
          errors <= errors + 1;
        end else begin
          m = match_q.pop_front();
          if (out_ch.window_score !== m.score || out_ch.window_valid !== m.valid ||
              out_ch.best_index !== m.bidx || out_ch.best_score !== m.bscore ||
              out_ch.best_found !== m.found || out_ch.search_done !== m.done) begin
            $display("%0t: expected score=%0d valid=%0b idx=%0d best=%0d found=%0b done=%0b",
                     $time, m.score, m.valid, m.bidx, m.bscore, m.found, m.done);
            $display("%0t:   actual score=%0d valid=%0b idx=%0d best=%0d found=%0b done=%0b",
                     $time, out_ch.window_score, out_ch.window_valid, out_ch.best_index,
                     out_ch.best_score, out_ch.best_found, out_ch.search_done);
            errors <= errors + 1;
          end
        end
      end
      // long hold-off once, so the block backs up and stalls its input
      if (results_seen == 100 && !long_hold_done) begin
        long_hold_done <= 1'b1;
        out_ch.ready   <= 1'b0;
        hold_cnt       <= 2000;
      end else if (hold_cnt > 0) begin
        out_ch.ready <= 1'b0;
        hold_cnt     <= hold_cnt - 1;
      end else begin
        case ($urandom_range(0, 99))
          0, 1, 2, 3, 4, 5, 6: begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= $urandom_range(0, 4);
          end
          7: begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= $urandom_range(20, 80);
          end
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    int len;
    logic sl;
    errors = 0;
    results_seen = 0;
    long_hold_done = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.window_byte = '0;
    in_ch.template_byte = '0;
    in_ch.window_last = 1'b0;
    in_ch.search_last = 1'b0;
    out_ch.ready = 1'b0;
    p_dot = '0; p_wsq = '0; p_tsq = '0;
    p_ord = '0; p_best_ord = '0; p_best = '0; p_seen = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // zero window, zero template, no best yet
    push_pair(8'd0, 8'd200, 1'b1, 1'b0);
    push_pair(8'd200, 8'd0, 1'b1, 1'b0);
    // orthogonal: valid with score zero
    push_pair(8'd255, 8'd0, 1'b0, 1'b0);
    push_pair(8'd0, 8'd255, 1'b1, 1'b0);
    // exact match gives 1.0, then a tie goes to the later window
    push_pair(8'd255, 8'd255, 1'b1, 1'b0);
    push_pair(8'd1, 8'd1, 1'b1, 1'b0);
    push_pair(8'd3, 8'd100, 1'b0, 1'b1);  // stray search mark
    push_pair(8'd100, 8'd3, 1'b1, 1'b0);
    push_pair(8'd170, 8'd85, 1'b1, 1'b1);  // search end
    // after search end: invalid only, then lower scores
    push_pair(8'd0, 8'd0, 1'b1, 1'b0);
    push_pair(8'd10, 8'd250, 1'b0, 1'b0);
    push_pair(8'd250, 8'd10, 1'b1, 1'b0);
    push_pair(8'd128, 8'd127, 1'b1, 1'b1);
    // single-byte search with a skewed pair
    push_pair(8'd255, 8'd1, 1'b1, 1'b1);

    // random windows
    for (int n = 0; n < 1150; n += len) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      sl = ($urandom_range(0, 99) < 15);
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) push_pair(rand_byte(), rand_byte(), 1'b1, sl);
        else push_pair(rand_byte(), rand_byte(), 1'b0, $urandom_range(0, 19) == 0);
      end
    end
    push_pair(8'($urandom), 8'($urandom), 1'b1, 1'b1);

    while (pair_q.size() != 0 || in_ch.valid || match_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
